// File: design/periodic_task_next_event_picker_core_defines.svh
// assertion macros shared by the checker
`ifndef PERIODIC_TASK_NEXT_EVENT_PICKER_CORE_DEFINES_SVH
`define PERIODIC_TASK_NEXT_EVENT_PICKER_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PTNEP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define PTNEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: design/ptnep_pkg.sv
package ptnep_pkg;
    localparam int unsigned Tasks = 8;
    localparam int unsigned TaskW = 3;
    localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture input word
        logic write;     // write table entry
        logic start;     // start deployment
        logic init;      // clear walk accumulators
        logic task_prep; // compute first, clear planned
        logic div_start; // launch divider
        logic slot_calc; // compute slot after division
        logic scan_init; // begin collision scan
        logic scan_step; // check one earlier task
        logic decide;    // accept or reject candidate
        logic commit;    // write last_run/run_count for pick
        logic next_task; // advance walk index
    } t_cmd_s;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       walk_done;  // walk index reached limit
        logic       early;      // now <= first
        logic       div_done;
        logic       scan_done;  // scan index reached task index or hit
    } t_sts_s;
endpackage

// File: design/ptnep_div.sv
module ptnep_div import ptnep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_trial;
    logic [32:0] w_sub;

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem[31:0], r_q[31]};
        w_sub   = w_trial - {1'b0, i_den};
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[32]) begin
                n_rem = w_sub;
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = !r_busy && !i_start;
    assign o_quot = r_q;
endmodule

// File: design/ptnep_datapath.sv
module ptnep_datapath import ptnep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd_s      i_ctl,
    input  logic [3:0]  i_task_count,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_task_index,
    input  logic [31:0] i_current_time,
    input  logic [31:0] i_start_delay,
    input  logic [31:0] i_run_interval,
    input  logic [31:0] i_run_duration,
    input  logic [31:0] i_lateness_limit,
    output t_sts_s      o_sts,
    output logic        o_found,
    output logic [2:0]  o_pick,
    output logic [31:0] o_best,
    output logic [3:0]  o_overruns
);
    logic [31:0] r_delay [Tasks];
    logic [31:0] r_ival  [Tasks];
    logic [31:0] r_dur   [Tasks];
    logic [31:0] r_lim   [Tasks];
    logic [31:0] r_first [Tasks];
    logic [31:0] r_last  [Tasks];
    logic [31:0] r_plan  [Tasks];
    logic [31:0] r_cnt   [Tasks];
    logic [31:0] r_dep;

    logic [1:0]  r_cmd;
    logic [2:0]  r_idx;
    logic [31:0] r_now, r_a, r_b, r_c, r_d;

    logic [3:0]  r_t;        // walk index
    logic [3:0]  r_k;        // scan index
    logic [31:0] r_firstv, r_slot, r_best, r_prev;
    logic [2:0]  r_pick;
    logic        r_found, r_hit;
    logic [3:0]  r_ovr;

    logic [2:0]  w_t;
    logic [2:0]  w_k;
    logic [31:0] w_iv, w_quot, w_first, w_prev, w_next, w_last;
    logic [31:0] w_os, w_oe;
    logic [3:0]  w_n;
    logic        w_div_done;
    logic        w_late;

    assign w_t    = r_t[2:0];
    assign w_k    = r_k[2:0];
    assign w_iv   = (r_ival[w_t] == '0) ? 32'd1 : r_ival[w_t];
    assign w_n    = (i_task_count > 4'(Tasks)) ? 4'(Tasks) : i_task_count;
    assign w_last = r_last[w_t];

    // effective first run for current task
    always_comb begin
        w_first = r_dep + r_delay[w_t];
        if (r_first[w_t] != AllOnes) begin
            w_first = r_first[w_t];
        end else if (w_last != AllOnes) begin
            w_first = w_last;
        end
    end

    ptnep_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (r_now - r_firstv - 32'd1),
        .i_den   (w_iv),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // quot*iv, one multiplier; prev = first + quot*iv
    assign w_prev = r_firstv + 32'(w_quot * w_iv);
    assign w_next = r_prev + w_iv;
    assign w_late = (w_last < r_prev) ||
                    (w_last == r_firstv && r_firstv < r_now && r_cnt[w_t] == '0);

    assign w_os = r_plan[w_k];
    assign w_oe = w_os + r_dur[w_k];

    // table and walk state
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_command;
            r_idx <= i_task_index;
            r_now <= i_current_time;
            r_a   <= i_start_delay;
            r_b   <= i_run_interval;
            r_c   <= i_run_duration;
            r_d   <= i_lateness_limit;
        end
        if (i_ctl.write) begin
            r_delay[r_idx] <= r_a;
            r_ival[r_idx]  <= r_b;
            r_dur[r_idx]   <= r_c;
            r_lim[r_idx]   <= r_d;
        end
        if (i_ctl.init) begin
            r_t     <= '0;
            r_best  <= AllOnes;
            r_pick  <= '0;
            r_found <= 1'b0;
            r_ovr   <= '0;
        end
        if (i_ctl.task_prep) begin
            r_firstv <= w_first;
            r_slot   <= w_first;
        end
        if (i_ctl.div_start) begin
            r_prev <= '0;
        end
        if (i_ctl.slot_calc) begin
            r_prev <= w_prev;
        end
        if (i_ctl.scan_init) begin
            // late path uses prev registered by slot_calc stage
            if (!o_sts.early) begin
                if (w_late) begin
                    r_slot <= ((r_now + r_dur[w_t]) > w_next) ? w_next : r_now;
                end else if (w_last == AllOnes) begin
                    r_slot <= r_now;
                end else begin
                    r_slot <= w_next;
                end
            end
            r_k   <= '0;
            r_hit <= 1'b0;
        end
        if (i_ctl.scan_step) begin
            if (w_os != AllOnes &&
                !((r_slot + r_dur[w_t]) <= w_os || w_oe <= r_slot)) begin
                r_hit <= 1'b1;
            end
            r_k <= r_k + 4'd1;
        end
        if (i_ctl.decide) begin
            if (o_sts.early) begin
                if (r_slot < r_best && !r_hit) begin
                    r_best  <= r_slot;
                    r_pick  <= w_t;
                    r_found <= 1'b1;
                end
            end else if (!r_hit) begin
                r_plan[w_t] <= r_slot;
                if (r_slot < r_best) begin
                    r_best  <= r_slot;
                    r_pick  <= w_t;
                    r_found <= 1'b1;
                    if ((r_slot - w_last) > r_lim[w_t]) begin
                        r_first[w_t] <= AllOnes;
                        if (r_cnt[w_t] != '0 && r_ovr != 4'd15) begin
                            r_ovr <= r_ovr + 4'd1;
                        end
                    end
                end
            end
        end
        if (i_ctl.next_task) begin
            r_t <= r_t + 4'd1;
        end
        if (i_ctl.commit && r_found) begin
            r_last[r_pick] <= r_best;
            r_cnt[r_pick]  <= r_cnt[r_pick] + 32'd1;
        end
        // prep writes folded first_run and clears plan; after decide order matters
        if (i_ctl.task_prep) begin
            r_plan[w_t]  <= AllOnes;
            r_first[w_t] <= w_first == r_dep + r_delay[w_t] && r_first[w_t] == AllOnes
                            && w_last == AllOnes ? AllOnes : w_first;
        end
        if (!i_rst_n) begin
            r_dep <= '0;
            for (int i = 0; i < Tasks; i++) begin
                r_first[i] <= AllOnes;
                r_last[i]  <= AllOnes;
                r_plan[i]  <= AllOnes;
                r_cnt[i]   <= '0;
            end
        end else if (i_ctl.start) begin
            r_dep <= r_now;
            for (int i = 0; i < Tasks; i++) begin
                r_first[i] <= AllOnes;
                r_last[i]  <= AllOnes;
                r_plan[i]  <= AllOnes;
                r_cnt[i]   <= '0;
            end
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.walk_done = (r_t >= w_n);
    assign o_sts.early     = (r_now <= r_firstv);
    assign o_sts.div_done  = w_div_done;
    assign o_sts.scan_done = (r_k >= r_t) || r_hit;
    assign o_found    = r_found;
    assign o_pick     = r_pick;
    assign o_best     = r_best;
    assign o_overruns = r_ovr;
endmodule

// File: design/ptnep_ctrl.sv
module ptnep_ctrl import ptnep_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_sts_s i_sts,
    output t_cmd_s o_ctl,
    output logic   o_res_load,
    input  logic   i_res_free
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_PREP, S_DIV, S_WAIT, S_SLOT, S_SCANI, S_SCAN,
        S_DECIDE, S_COMMIT
    } t_state;

    t_state r_state, n_state;

    // sequencer
    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_res_load = 1'b0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_WRITE: begin
                        o_ctl.write = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_START: begin
                        o_ctl.start = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_NEXT: begin
                        o_ctl.init = 1'b1;
                        n_state = S_PREP;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_PREP: begin
                if (i_sts.walk_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_ctl.task_prep = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.early) begin
                    n_state = S_SCANI;
                end else begin
                    o_ctl.div_start = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                o_ctl.slot_calc = 1'b1;
                n_state = S_SCANI;
            end
            S_SCANI: begin
                o_ctl.scan_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_DECIDE: begin
                o_ctl.decide    = 1'b1;
                o_ctl.next_task = 1'b1;
                n_state = S_PREP;
            end
            S_COMMIT: begin
                if (i_res_free) begin
                    o_ctl.commit = 1'b1;
                    o_res_load   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: design/periodic_task_next_event_picker_core.sv
// periodic task next-event picker
// input channel: one word per command (write entry, start, next); accepted
// on i_in_valid && o_in_ready. o_in_ready is high only between commands.
// config channel: i_cfg_valid/o_cfg_ready writes task_count, always ready;
// write only while idle.
// output channel: one word per next command, held in an output register
// until i_out_ready takes it; a new command may be accepted
// while that word waits.
// sequencing: write and start are captured in S_IDLE and applied in S_DECODE;
// next walks the tasks in order through S_PREP and S_DIV, then, for a task
// already due, the bit-serial divider (S_WAIT) and S_SLOT, then S_SCANI, the
// serial overlap scan of earlier tasks (S_SCAN) and S_DECIDE; it ends in S_COMMIT.
// reset clears the run state, task_count and deployment start; task
// table entries are undefined until written.
// if the receiver stalls with a word pending, the next walk finishes and
// holds in its final step until the output register frees.
module periodic_task_next_event_picker_core import ptnep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_task_count,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_task_index,
    input  logic [31:0] i_current_time,
    input  logic [31:0] i_start_delay,
    input  logic [31:0] i_run_interval,
    input  logic [31:0] i_run_duration,
    input  logic [31:0] i_lateness_limit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [2:0]  o_chosen_task,
    output logic [31:0] o_run_time,
    output logic [3:0]  o_overrun_events
);
    t_cmd_s      w_ctl;
    t_sts_s      w_sts;
    logic        w_res_load, w_found;
    logic [2:0]  w_pick;
    logic [31:0] w_best;
    logic [3:0]  w_ovr;
    logic [3:0]  r_tc;
    logic        r_ov;

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
        end else if (i_cfg_valid) begin
            r_tc <= i_task_count;
        end
    end

    ptnep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_res_load (w_res_load),
        .i_res_free (!r_ov || i_out_ready)
    );

    ptnep_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .i_task_count     (r_tc),
        .i_command        (i_command),
        .i_task_index     (i_task_index),
        .i_current_time   (i_current_time),
        .i_start_delay    (i_start_delay),
        .i_run_interval   (i_run_interval),
        .i_run_duration   (i_run_duration),
        .i_lateness_limit (i_lateness_limit),
        .o_sts            (w_sts),
        .o_found          (w_found),
        .o_pick           (w_pick),
        .o_best           (w_best),
        .o_overruns       (w_ovr)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_res_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
        if (w_res_load) begin
            o_status         <= !w_found;
            o_chosen_task    <= w_found ? w_pick : 3'd0;
            o_run_time       <= w_found ? w_best : 32'd0;
            o_overrun_events <= w_found ? w_ovr : 4'd0;
        end
    end
    assign o_out_valid = r_ov;
endmodule

// File: design/ptnep_checker.sv
`include "periodic_task_next_event_picker_core_defines.svh"
module ptnep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_status,
    input logic [2:0]  o_chosen_task,
    input logic [31:0] o_run_time,
    input logic [3:0]  o_overrun_events
);
    // pending word holds until taken
    `PTNEP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    // a no-task word carries zero fields
    `PTNEP_ASSERT_IMPL(a_none, i_clk, i_rst_n, o_out_valid && o_status,
        o_chosen_task == 3'd0 && o_run_time == 32'd0 && o_overrun_events == 4'd0)
    // accepted command blocks input next cycle
    `PTNEP_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule

bind periodic_task_next_event_picker_core ptnep_checker u_chk (.*);

// File: tb/sv/periodic_task_next_event_picker_core_checker.sv
// watches the three channels, keeps its own copy of the task table and run
// state, predicts each next-event word and compares it with the output word
module periodic_task_next_event_picker_core_checker import ptnep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_task_count,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_task_index,
    input  logic [31:0] i_current_time,
    input  logic [31:0] i_start_delay,
    input  logic [31:0] i_run_interval,
    input  logic [31:0] i_run_duration,
    input  logic [31:0] i_lateness_limit,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_status,
    input  logic [2:0]  i_chosen_task,
    input  logic [31:0] i_run_time,
    input  logic [3:0]  i_overrun_events,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        status;
        logic [2:0]  chosen;
        logic [31:0] run_at;
        logic [3:0]  overruns;
    } t_pick;

    // mirror of the block state
    logic [31:0] delay_q    [Tasks];
    logic [31:0] interval_q [Tasks];
    logic [31:0] duration_q [Tasks];
    logic [31:0] limit_q    [Tasks];
    logic [31:0] first_q    [Tasks];
    logic [31:0] last_q     [Tasks];
    logic [31:0] planned_q  [Tasks];
    logic [31:0] runs_q     [Tasks];
    logic [31:0] deploy_q;
    logic [3:0]  count_q;
    t_pick       pick_queue [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = pick_queue.size();

    function automatic void clear_run_state();
        for (int i = 0; i < Tasks; i++) begin
            first_q[i]   = AllOnes;
            last_q[i]    = AllOnes;
            planned_q[i] = AllOnes;
            runs_q[i]    = '0;
        end
    endfunction

    // overlap of a candidate slot with the plans of earlier tasks
    function automatic bit overlaps(int t, logic [31:0] slot);
        logic [31:0] slot_end;
        logic [31:0] other_end;
        slot_end = slot + duration_q[t];
        for (int k = 0; k < t; k++) begin
            if (planned_q[k] == AllOnes) continue;
            other_end = planned_q[k] + duration_q[k];
            if (!(slot_end <= planned_q[k] || other_end <= slot)) return 1'b1;
        end
        return 1'b0;
    endfunction

    // one walk over the table for a next command
    function automatic t_pick pick_next_event(logic [31:0] now);
        t_pick       res;
        logic [31:0] best, first, iv, due, prev, nxt, slot;
        bit          found;
        int          chosen, n;
        logic [3:0]  overruns;
        best = AllOnes;
        found = 0;
        chosen = 0;
        overruns = '0;
        n = (count_q > Tasks) ? Tasks : count_q;
        for (int t = 0; t < n; t++) begin
            first = deploy_q + delay_q[t];
            iv = (interval_q[t] != 0) ? interval_q[t] : 32'd1;
            planned_q[t] = AllOnes;
            if (first_q[t] == AllOnes && last_q[t] != AllOnes) first_q[t] = last_q[t];
            if (first_q[t] != AllOnes) first = first_q[t];
            if (now <= first) begin
                if (first < best && !overlaps(t, first)) begin
                    best = first;
                    chosen = t;
                    found = 1;
                end
                continue;
            end
            due  = (now - first - 32'd1) / iv + 32'd1;
            prev = first + (due - 32'd1) * iv;
            nxt  = prev + iv;
            if (last_q[t] < prev ||
                (last_q[t] == first && first < now && runs_q[t] == 0)) begin
                slot = (now + duration_q[t] > nxt) ? nxt : now;
            end else if (last_q[t] == AllOnes) begin
                slot = now;
            end else begin
                slot = nxt;
            end
            if (!overlaps(t, slot)) begin
                planned_q[t] = slot;
                if (slot < best) begin
                    best = slot;
                    chosen = t;
                    found = 1;
                    if (slot - last_q[t] > limit_q[t]) begin
                        first_q[t] = AllOnes;
                        if (runs_q[t] != 0 && overruns != 4'd15) overruns++;
                    end
                end
            end
        end
        if (!found) begin
            res = '{status: 1'b1, chosen: '0, run_at: '0, overruns: '0};
        end else begin
            last_q[chosen] = best;
            runs_q[chosen] = runs_q[chosen] + 32'd1;
            res = '{status: 1'b0, chosen: chosen[2:0], run_at: best, overruns: overruns};
        end
        return res;
    endfunction

    // prediction on accepted words, comparison on delivered words
    always @(posedge i_clk) begin
        t_pick got, exp_pick;
        if (!i_rst_n) begin
            deploy_q = '0;
            count_q  = '0;
            clear_run_state();
            pick_queue.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) count_q = i_task_count;
            if (i_in_valid && i_in_ready) begin
                case (t_cmd'(i_command))
                    CMD_WRITE: begin
                        delay_q[i_task_index]    = i_start_delay;
                        interval_q[i_task_index] = i_run_interval;
                        duration_q[i_task_index] = i_run_duration;
                        limit_q[i_task_index]    = i_lateness_limit;
                    end
                    CMD_START: begin
                        deploy_q = i_current_time;
                        clear_run_state();
                    end
                    CMD_NEXT: pick_queue.push_back(pick_next_event(i_current_time));
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{status: i_status, chosen: i_chosen_task, run_at: i_run_time,
                        overruns: i_overrun_events};
                if (pick_queue.size() == 0) begin
                    $error("unexpected output word");
                    fails++;
                end else begin
                    exp_pick = pick_queue.pop_front();
                    if (got.status !== exp_pick.status) begin
                        $error("status: expected %0d actual %0d", exp_pick.status, got.status);
                        fails++;
                    end
                    if (got.chosen !== exp_pick.chosen) begin
                        $error("chosen_task: expected %0d actual %0d",
                               exp_pick.chosen, got.chosen);
                        fails++;
                    end
                    if (got.run_at !== exp_pick.run_at) begin
                        $error("run_time: expected %h actual %h", exp_pick.run_at, got.run_at);
                        fails++;
                    end
                    if (got.overruns !== exp_pick.overruns) begin
                        $error("overrun_events: expected %0d actual %0d",
                               exp_pick.overruns, got.overruns);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/periodic_task_next_event_picker_core_tb.sv
module periodic_task_next_event_picker_core_tb;
    import ptnep_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [3:0]  i_task_count = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_command = CMD_NONE;
    logic [2:0]  i_task_index = '0;
    logic [31:0] i_current_time = '0;
    logic [31:0] i_start_delay = '0;
    logic [31:0] i_run_interval = '0;
    logic [31:0] i_run_duration = '0;
    logic [31:0] i_lateness_limit = '0;
    logic        i_out_ready = 1'b0;
    logic        o_cfg_ready, o_in_ready, o_out_valid, o_status;
    logic [2:0]  o_chosen_task;
    logic [31:0] o_run_time;
    logic [3:0]  o_overrun_events;
    int          fail_count, pending;
    int          send_idle = 0;
    int          recv_idle = 0;
    logic [31:0] tick_now = '0;

    periodic_task_next_event_picker_core uut (.*);

    periodic_task_next_event_picker_core_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_task_count,
        .i_in_valid, .i_in_ready(o_in_ready), .i_command, .i_task_index,
        .i_current_time, .i_start_delay, .i_run_interval, .i_run_duration,
        .i_lateness_limit, .i_out_valid(o_out_valid), .i_out_ready, .i_status(o_status),
        .i_chosen_task(o_chosen_task), .i_run_time(o_run_time),
        .i_overrun_events(o_overrun_events), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // one word on the input channel, with random gaps before it
    task automatic send_word(t_cmd cmd, logic [2:0] idx, logic [31:0] now,
                             logic [31:0] dly, logic [31:0] ivl,
                             logic [31:0] dur, logic [31:0] lim);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_task_index     <= idx;
        i_current_time   <= now;
        i_start_delay    <= dly;
        i_run_interval   <= ivl;
        i_run_duration   <= dur;
        i_lateness_limit <= lim;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // wait for the block to drain, then write task_count
    task automatic set_task_count(logic [3:0] value);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (450) @(posedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_task_count <= value;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_entry(logic [2:0] idx);
        if ($urandom_range(9) == 0)
            send_word(CMD_WRITE, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send_word(CMD_WRITE, idx, $urandom, $urandom_range(200), $urandom_range(1, 80),
                      $urandom_range(20), $urandom_range(300));
    endtask

    // mostly short steps of time with occasional jumps and wraps
    task automatic random_word();
        int roll;
        roll = $urandom_range(99);
        if ($urandom_range(19) == 0) tick_now = $urandom;
        else tick_now = tick_now + $urandom_range(60);
        if (roll < 60)
            send_word(CMD_NEXT, 3'($urandom), tick_now, $urandom, $urandom, $urandom,
                      $urandom);
        else if (roll < 82)
            write_entry(3'($urandom));
        else if (roll < 95)
            send_word(CMD_START, 3'($urandom), tick_now - $urandom_range(100),
                      $urandom, $urandom, $urandom, $urandom);
        else
            send_word(CMD_NONE, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
                      $urandom);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme entries, every command, wrap and clamp cases
        send_word(CMD_WRITE, 3'd0, '0, '0, 32'd0, '0, '0);
        send_word(CMD_WRITE, 3'd1, '0, AllOnes, AllOnes, AllOnes, AllOnes);
        send_word(CMD_WRITE, 3'd2, '0, 32'd5, 32'd1, 32'd3, '0);
        send_word(CMD_WRITE, 3'd3, '0, 32'd10, 32'd7, 32'd2, 32'd4);
        send_word(CMD_WRITE, 3'd4, '0, 32'd0, 32'd3, 32'd0, 32'd100);
        send_word(CMD_WRITE, 3'd5, '0, 32'd2, 32'd9, 32'd8, 32'd1);
        send_word(CMD_WRITE, 3'd6, '0, 32'd40, 32'd13, 32'd1, 32'd50);
        send_word(CMD_WRITE, 3'd7, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5, AllOnes);
        set_task_count(4'd8);
        send_word(CMD_NEXT, 3'd0, 32'd0, '0, '0, '0, '0);
        send_word(CMD_NEXT, 3'd0, 32'd3, '0, '0, '0, '0);
        send_word(CMD_NEXT, 3'd0, 32'd200, '0, '0, '0, '0);
        send_word(CMD_NEXT, 3'd0, AllOnes, '0, '0, '0, '0);
        send_word(CMD_START, 3'd0, 32'hFFFF_FFF0, '0, '0, '0, '0);
        send_word(CMD_NEXT, 3'd0, 32'h0000_0020, '0, '0, '0, '0);
        send_word(CMD_NONE, 3'd7, AllOnes, AllOnes, AllOnes, AllOnes, AllOnes);
        set_task_count(4'd15);
        send_word(CMD_NEXT, 3'd0, 32'h0000_0400, '0, '0, '0, '0);
        send_word(CMD_START, 3'd0, '0, '0, '0, '0, '0);
        set_task_count(4'd0);
        send_word(CMD_NEXT, 3'd0, 32'd50, '0, '0, '0, '0);

        // random phases with changing idling and task_count
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 11 : (phase == 1) ? 76 : 0;
            recv_idle = (phase == 0) ? 76 : (phase == 1) ? 11 : 0;
            for (int i = 0; i < 8; i++) write_entry(3'(i));
            send_word(CMD_START, 3'd0, tick_now, '0, '0, '0, '0);
            for (int blk = 0; blk < 5; blk++) begin
                case ($urandom_range(3))
                    0: set_task_count(4'd8);
                    1: set_task_count(4'd15);
                    2: set_task_count(4'd1);
                    default: set_task_count(4'($urandom_range(15)));
                endcase
                for (int i = 0; i < 100; i++) random_word();
            end
        end

        // drain
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (500) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
